// ===== hw/rtl/lru2_buffer_replacement_assert.svh =====
`ifndef LRU2_BUFFER_REPLACEMENT_ASSERT_SVH
`define LRU2_BUFFER_REPLACEMENT_ASSERT_SVH
// Assertion macros for the replacement block.
`define LRU2_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LRU2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/lru2_pkg.sv =====
package lru2_pkg;
    localparam int FrameCountDef = 64;
    localparam int TimeBitsDef = 32;
    localparam int FrameW = 6;
    localparam int TimeW = 32;

    typedef enum logic [1:0] {
        REQ_FIRST   = 2'd0,
        REQ_PROMOTE = 2'd1,
        REQ_REACC   = 2'd2,
        REQ_VICTIM  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [FrameW-1:0] frame_no;
        logic [TimeW-1:0]  first_time;
        logic [TimeW-1:0]  second_time;
    } t_in;

    typedef struct packed {
        logic [FrameW-1:0] victim_frame;
        logic              victim_valid;
        logic              error_flag;
    } t_out;

    // Per-cell command given to a whole list; during OP_MOVE the list turns it into a hold per cell.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_MOVE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [FrameW-1:0] frame;
    } t_ctl;
endpackage

// ===== hw/rtl/lru2_cell.sv =====
module lru2_cell
    import lru2_pkg::*;
#(
    parameter int KeyBits = 33
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic signed [KeyBits-1:0] i_key,
    input  logic                      i_prev_ins,
    input  logic                      i_prev_rem,
    input  logic                      i_prev_valid,
    input  logic [FrameW-1:0]         i_prev_frame,
    input  logic signed [KeyBits-1:0] i_prev_key,
    input  logic                      i_next_valid,
    input  logic [FrameW-1:0]         i_next_frame,
    input  logic signed [KeyBits-1:0] i_next_key,
    input  logic                      i_use_key,
    output logic                      o_ins,
    output logic                      o_rem,
    output logic                      o_valid,
    output logic [FrameW-1:0]         o_frame,
    output logic signed [KeyBits-1:0] o_key
);
    logic                      r_valid;
    logic [FrameW-1:0]         r_frame;
    logic signed [KeyBits-1:0] r_key;
    logic                      here_ins;
    logic                      here_rem;

    // Insert point: first valid cell at or above the new key (or first empty); the head without i_use_key.
    assign here_ins = i_use_key ? (!r_valid || (r_key >= i_key)) : 1'b1;
    assign o_ins = i_prev_ins || here_ins;
    assign here_rem = r_valid && (r_frame == i_ctl.frame);
    assign o_rem = i_prev_rem || here_rem;
    assign o_valid = r_valid;
    assign o_frame = r_frame;
    assign o_key = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_INSERT: begin
                    if (i_prev_ins) begin
                        r_valid <= i_prev_valid;
                        r_frame <= i_prev_frame;
                        r_key   <= i_prev_key;
                    end else if (here_ins) begin
                        r_valid <= 1'b1;
                        r_frame <= i_ctl.frame;
                        r_key   <= i_key;
                    end
                end
                OP_REMOVE: begin
                    if (o_rem) begin
                        r_valid <= i_next_valid;
                        r_frame <= i_next_frame;
                        r_key   <= i_next_key;
                    end
                end
                OP_MOVE: begin
                    r_valid <= i_next_valid;
                end
                default: begin
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/lru2_list.sv =====
module lru2_list
    import lru2_pkg::*;
#(
    parameter int Depth   = FrameCountDef,
    parameter int KeyBits = TimeBitsDef + 1,
    parameter bit UseKey  = 1'b1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic signed [KeyBits-1:0] i_key,
    output logic                      o_found,
    output logic                      o_full,
    output logic                      o_empty,
    output logic [FrameW-1:0]         o_tail
);
    logic                      ins_c [Depth+1];
    logic                      rem_c [Depth+1];
    logic                      val_c [Depth+2];
    logic [FrameW-1:0]         frm_c [Depth+2];
    logic signed [KeyBits-1:0] key_c [Depth+2];
    logic [FrameW-1:0]         tail_sel [Depth+1];

    assign ins_c[0] = 1'b0;
    assign rem_c[0] = 1'b0;
    assign val_c[0] = 1'b0;
    assign frm_c[0] = '0;
    assign key_c[0] = '0;
    assign val_c[Depth+1] = 1'b0;
    assign frm_c[Depth+1] = '0;
    assign key_c[Depth+1] = '0;

    // During OP_MOVE only cells whose next cell is empty take that cell's valid bit; the tail
    // cell is the last valid one, so this clears its valid bit and removes it.
    genvar g;
    generate
        for (g = 0; g < Depth; g++) begin : g_cell
            t_ctl cell_ctl;
            always_comb begin
                cell_ctl = i_ctl;
                if (i_ctl.op == OP_MOVE) begin
                    cell_ctl.op = val_c[g+2] ? OP_HOLD : OP_MOVE;
                end
            end
            lru2_cell #(.KeyBits(KeyBits)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (cell_ctl),
                .i_key        (i_key),
                .i_prev_ins   (ins_c[g]),
                .i_prev_rem   (rem_c[g]),
                .i_prev_valid (val_c[g]),
                .i_prev_frame (frm_c[g]),
                .i_prev_key   (key_c[g]),
                .i_next_valid (val_c[g+2]),
                .i_next_frame (frm_c[g+2]),
                .i_next_key   (key_c[g+2]),
                .i_use_key    (UseKey),
                .o_ins        (ins_c[g+1]),
                .o_rem        (rem_c[g+1]),
                .o_valid      (val_c[g+1]),
                .o_frame      (frm_c[g+1]),
                .o_key        (key_c[g+1])
            );
            assign tail_sel[g+1] = (val_c[g+1] && !val_c[g+2]) ? frm_c[g+1] : tail_sel[g];
        end
    endgenerate

    assign tail_sel[0] = '0;
    assign o_found = rem_c[Depth];
    assign o_full  = val_c[Depth];
    assign o_empty = !val_c[1];
    assign o_tail  = tail_sel[Depth];
endmodule

// ===== hw/rtl/lru2_buffer_replacement.sv =====
// An item is accepted only in the idle state. In the work state both lists are searched
// and shifted and the result is registered, then offered in the output state; a successful
// promote or re-access first inserts into the twice-list in the output state.
// No new item is accepted until the result has been taken, so a stall on the result
// holds off the next item.
// Reset (synchronous, active low) empties both lists and drops any result.
module lru2_buffer_replacement
    import lru2_pkg::*;
#(
    parameter int FRAME_COUNT = FrameCountDef,
    parameter int TIME_BITS   = TimeBitsDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    localparam int KeyBits = TIME_BITS + 1;
    localparam int UsedBits = (TIME_BITS < TimeW) ? TIME_BITS : TimeW;

    t_state r_state, n_state;
    t_in    r_req;
    t_out   r_out, n_out;
    t_ctl   once_ctl, twice_ctl;
    logic   r_twice_ins, n_twice_ins;
    logic signed [KeyBits-1:0] r_key, n_key;
    logic signed [KeyBits-1:0] zero_key;
    logic   once_found, once_full, once_empty;
    logic   twice_found, twice_full, twice_empty;
    logic [FrameW-1:0] once_tail, twice_tail;
    logic [KeyBits-1:0] t1, t2;

    assign zero_key = '0;
    assign t1 = KeyBits'(r_req.first_time[UsedBits-1:0]);
    assign t2 = KeyBits'(r_req.second_time[UsedBits-1:0]);

    lru2_list #(.Depth(FRAME_COUNT), .KeyBits(KeyBits), .UseKey(1'b0)) u_once (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(once_ctl), .i_key(zero_key),
        .o_found(once_found), .o_full(once_full), .o_empty(once_empty),
        .o_tail(once_tail)
    );

    lru2_list #(.Depth(FRAME_COUNT), .KeyBits(KeyBits), .UseKey(1'b1)) u_twice (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(twice_ctl), .i_key(r_key),
        .o_found(twice_found), .o_full(twice_full), .o_empty(twice_empty),
        .o_tail(twice_tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (i_valid && o_ready) begin
            r_req <= i_data;
        end
        r_out       <= n_out;
        r_twice_ins <= n_twice_ins;
        r_key       <= n_key;
    end

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_twice_ins = 1'b0;
        n_key       = r_key;
        once_ctl    = '{op: OP_HOLD, frame: r_req.frame_no};
        twice_ctl   = '{op: OP_HOLD, frame: r_req.frame_no};
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK: begin
                n_out   = '{victim_frame: '0, victim_valid: 1'b0, error_flag: 1'b0};
                n_state = ST_OUT;
                case (r_req.req_type)
                    REQ_FIRST: begin
                        if (once_full) begin
                            n_out.error_flag = 1'b1;
                        end else begin
                            once_ctl.op = OP_INSERT;
                        end
                    end
                    REQ_PROMOTE: begin
                        if (!once_found || twice_full) begin
                            n_out.error_flag = 1'b1;
                        end else begin
                            once_ctl.op = OP_REMOVE;
                            n_key       = t2 - t1;
                            n_twice_ins = 1'b1;
                        end
                    end
                    REQ_REACC: begin
                        if (!twice_found) begin
                            n_out.error_flag = 1'b1;
                        end else begin
                            twice_ctl.op = OP_REMOVE;
                            n_key        = t1 - t2;
                            n_twice_ins  = 1'b1;
                        end
                    end
                    default: begin
                        if (!once_empty) begin
                            once_ctl.op = OP_MOVE;
                            n_out.victim_frame = once_tail;
                            n_out.victim_valid = 1'b1;
                        end else if (!twice_empty) begin
                            twice_ctl.op = OP_MOVE;
                            n_out.victim_frame = twice_tail;
                            n_out.victim_valid = 1'b1;
                        end else begin
                            n_out.error_flag = 1'b1;
                        end
                    end
                endcase
            end
            ST_OUT: begin
                if (r_twice_ins) begin
                    twice_ctl.op = OP_INSERT;
                end else begin
                    o_valid = 1'b1;
                    if (i_ready) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_data = r_out;

`include "lru2_buffer_replacement_assert.svh"
    `LRU2_ASSERT_IMPL(a_out_excl, o_valid,
        !(r_out.victim_valid && r_out.error_flag), "victim and error together")
    `LRU2_ASSERT_IMPL(a_ready_idle, o_ready, !o_valid, "ready while result pending")
    `LRU2_ASSERT_NEXT(a_accept_work, i_valid && o_ready, r_state == ST_WORK,
        "accepted item not worked")
endmodule

// ===== tb/lru2_buffer_replacement_test.sv =====
`timescale 1ns / 100ps

module lru2_buffer_replacement_test;
    import lru2_pkg::*;

    localparam int Frames = 64;
    localparam int TimeoutCycles = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;
    logic o_ready_seen;

    lru2_buffer_replacement dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    // Predicted list contents.
    logic [FrameW-1:0] once_list[$];
    logic [FrameW-1:0] twice_list[$];
    logic signed [TimeW:0] twice_dist[$];

    t_in  pending_items[$];
    t_out expected_results[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_cycles;
    int mismatches;
    int cycles;

    // Keeps the twice-list ascending; a new entry goes before equal distances.
    function automatic void insert_twice(logic [FrameW-1:0] f, logic signed [TimeW:0] d);
        int pos;
        pos = 0;
        while (pos < twice_list.size() && twice_dist[pos] < d) pos++;
        twice_list.insert(pos, f);
        twice_dist.insert(pos, d);
    endfunction

    function automatic t_out predict_replacement(t_in it);
        t_out r;
        int i;
        logic signed [TimeW:0] d;
        r = '0;
        case (t_req'(it.req_type))
            REQ_FIRST: begin
                if (once_list.size() >= Frames) r.error_flag = 1'b1;
                else once_list.push_front(it.frame_no);
            end
            REQ_PROMOTE: begin
                for (i = 0; i < once_list.size(); i++) if (once_list[i] == it.frame_no) break;
                if (i >= once_list.size() || twice_list.size() >= Frames) begin
                    r.error_flag = 1'b1;
                end else begin
                    once_list.delete(i);
                    d = $signed({1'b0, it.second_time}) - $signed({1'b0, it.first_time});
                    insert_twice(it.frame_no, d);
                end
            end
            REQ_REACC: begin
                for (i = 0; i < twice_list.size(); i++) if (twice_list[i] == it.frame_no) break;
                if (i >= twice_list.size()) begin
                    r.error_flag = 1'b1;
                end else begin
                    twice_list.delete(i);
                    twice_dist.delete(i);
                    d = $signed({1'b0, it.first_time}) - $signed({1'b0, it.second_time});
                    insert_twice(it.frame_no, d);
                end
            end
            default: begin
                if (once_list.size() > 0) begin
                    r.victim_frame = once_list.pop_back();
                    r.victim_valid = 1'b1;
                end else if (twice_list.size() > 0) begin
                    r.victim_frame = twice_list.pop_back();
                    void'(twice_dist.pop_back());
                    r.victim_valid = 1'b1;
                end else begin
                    r.error_flag = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [TimeW-1:0] rand_time();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(t_req rq, logic [FrameW-1:0] f, logic [TimeW-1:0] t1,
                            logic [TimeW-1:0] t2);
        t_in it;
        it.req_type = rq;
        it.frame_no = f;
        it.first_time = t1;
        it.second_time = t2;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || (i_valid && o_ready_seen)) begin
            if (pending_items.size() > 0 && $urandom_range(1, 100) > sender_idle_pct) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Acceptance is noted at the rising edge so the driver never depends on race order.
    always @(posedge i_clk) begin
        o_ready_seen <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(predict_replacement(i_data));
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(1, 100) > receiver_stall_pct);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", o_data);
            end else begin
                e = expected_results.pop_front();
                if (o_data.victim_frame !== e.victim_frame
                        || o_data.victim_valid !== e.victim_valid
                        || o_data.error_flag !== e.error_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", e, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= TimeoutCycles) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Random traffic: mostly first accesses, promotions and re-accesses, mostly of frames 0 to 11.
    task automatic random_phase(int count);
        logic [FrameW-1:0] f;
        int k;
        for (k = 0; k < count; k++) begin
            f = $urandom_range(0, 3) == 0 ? FrameW'($urandom) : FrameW'($urandom_range(0, 11));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_item(REQ_FIRST, f, rand_time(), rand_time());
                4, 5: add_item(REQ_PROMOTE, f, rand_time(), rand_time());
                6, 7: add_item(REQ_REACC, f, rand_time(), rand_time());
                default: add_item(REQ_VICTIM, FrameW'($urandom), $urandom, $urandom);
            endcase
        end
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        o_ready_seen = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        mismatches = 0;
        cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_item(REQ_VICTIM, '0, '0, '0);
        add_item(REQ_PROMOTE, 6'd5, '0, '0);
        add_item(REQ_REACC, 6'd5, '0, '0);
        add_item(REQ_FIRST, 6'd0, '0, '0);
        add_item(REQ_FIRST, 6'd63, '1, '1);
        add_item(REQ_FIRST, 6'd63, '0, '0);
        add_item(REQ_FIRST, 6'd7, '0, '0);
        add_item(REQ_PROMOTE, 6'd63, '0, '1);
        add_item(REQ_PROMOTE, 6'd7, '1, '0);
        add_item(REQ_PROMOTE, 6'd0, 32'd5, 32'd5);
        add_item(REQ_REACC, 6'd63, '0, '1);
        add_item(REQ_REACC, 6'd7, 32'd9, 32'd9);
        add_item(REQ_REACC, 6'd2, '0, '0);
        for (k = 0; k < 4; k++) add_item(REQ_VICTIM, '0, '0, '0);
        wait_drained();

        // Fill both lists to capacity and overflow them.
        for (k = 0; k < Frames + 1; k++) add_item(REQ_FIRST, FrameW'(k), '0, '0);
        for (k = 0; k < Frames; k++) add_item(REQ_PROMOTE, FrameW'(k), $urandom, $urandom);
        for (k = 0; k < Frames; k++) add_item(REQ_FIRST, FrameW'(k), '0, '0);
        add_item(REQ_FIRST, 6'd1, '0, '0);
        add_item(REQ_PROMOTE, 6'd1, '0, '0);
        for (k = 0; k < 2 * Frames + 1; k++) add_item(REQ_VICTIM, '0, '0, '0);
        wait_drained();

        random_phase(40);
        wait_drained();
        sender_idle_pct = 50;
        random_phase(40);
        wait_drained();
        sender_idle_pct = 0;
        receiver_stall_pct = 50;
        hold_off_cycles = 300;
        random_phase(40);
        wait_drained();
        sender_idle_pct = 34;
        receiver_stall_pct = 34;
        random_phase(40);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
